FILE: sv/bfau_pkg.sv
// ----------------------------------------------------------------------------
// bfau_pkg
// Types, constants, field multiplier and microcode table of the GF(2^m) unit.
// ----------------------------------------------------------------------------
package bfau_pkg;

   localparam int FIELD_BITS    = 32;
   localparam int OPERAND_BITS  = 32;
   localparam int EXP_BITS      = 32;
   localparam int KIND_BITS     = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_IDX_BITS  = CSR_ADDR_BITS - 2;
   localparam int STEP_BITS     = 4;

   typedef logic [FIELD_BITS-1:0] elem_type;
   typedef logic [EXP_BITS-1:0]   exp_type;
   typedef logic [STEP_BITS-1:0]  step_type;

   localparam logic [CSR_DATA_BITS-1:0] POLY_RESET   = CSR_DATA_BITS'(141);
   localparam logic [CSR_IDX_BITS-1:0]  REG_POLY_IDX = CSR_IDX_BITS'(0);
   localparam elem_type ELEM_ONE = FIELD_BITS'(1);
   localparam exp_type  INV_EXP  = EXP_BITS'((64'd1 << FIELD_BITS) - 64'd2);

   typedef enum logic [KIND_BITS-1:0] {
      KIND_ADD = 3'd0,
      KIND_SUB = 3'd1,
      KIND_NEG = 3'd2,
      KIND_MUL = 3'd3,
      KIND_INV = 3'd4,
      KIND_DIV = 3'd5,
      KIND_POW = 3'd6
   } kind_type;

   typedef enum logic [1:0] {MX_ACC, MX_BASE, MX_OPA} mx_sel_type;
   typedef enum logic [1:0] {MY_BASE, MY_OPA, MY_OPB} my_sel_type;
   typedef enum logic [2:0] {
      ACC_HOLD, ACC_ONE, ACC_ZERO, ACC_XOR, ACC_OPA, ACC_MUL, ACC_MUL_BIT
   } acc_op_type;
   typedef enum logic [2:0] {
      BASE_HOLD, BASE_OPA, BASE_OPB, BASE_ACC, BASE_MUL
   } base_op_type;
   typedef enum logic [2:0] {
      EXP_HOLD, EXP_INV, EXP_OPB, EXP_MAG, EXP_SHIFT
   } exp_op_type;
   typedef enum logic [2:0] {
      SEQ_NEXT, SEQ_JUMP, SEQ_JUMP_IF_ZERO, SEQ_DONE, SEQ_DONE_IF_ZERO
   } seq_type;

   typedef struct packed {
      mx_sel_type  mx;
      my_sel_type  my;
      acc_op_type  acc_op;
      base_op_type base_op;
      exp_op_type  exp_op;
      seq_type     seq;
      step_type    target;
   } ctrl_type;

   localparam step_type UC_ADD      = STEP_BITS'(0);
   localparam step_type UC_NEG      = STEP_BITS'(1);
   localparam step_type UC_MUL      = STEP_BITS'(2);
   localparam step_type UC_ZERO     = STEP_BITS'(3);
   localparam step_type UC_INV      = STEP_BITS'(4);
   localparam step_type UC_INV_MUL  = STEP_BITS'(5);
   localparam step_type UC_INV_SQR  = STEP_BITS'(6);
   localparam step_type UC_DIV      = STEP_BITS'(7);
   localparam step_type UC_DIV_MUL  = STEP_BITS'(8);
   localparam step_type UC_DIV_SQR  = STEP_BITS'(9);
   localparam step_type UC_DIV_FIN  = STEP_BITS'(10);
   localparam step_type UC_PPOW     = STEP_BITS'(11);
   localparam step_type UC_NPOW     = STEP_BITS'(12);
   localparam step_type UC_NPOW_MUL = STEP_BITS'(13);
   localparam step_type UC_NPOW_SQR = STEP_BITS'(14);
   localparam step_type UC_NPOW_RUN = STEP_BITS'(15);

   function automatic elem_type gf_mul(elem_type x, elem_type y, elem_type poly);
      elem_type acc;
      elem_type xs;
      acc = '0;
      xs  = x;
      for (int i = 0; i < FIELD_BITS; i++) begin
         if (y[i]) begin
            acc = acc ^ xs;
         end
         if (xs[FIELD_BITS-1]) begin
            xs = (xs << 1) ^ poly;
         end else begin
            xs = xs << 1;
         end
      end
      return acc;
   endfunction

   function automatic ctrl_type mk_ctrl(mx_sel_type mx, my_sel_type my, acc_op_type ao,
                                        base_op_type bo, exp_op_type eo, seq_type sq,
                                        step_type tg);
      ctrl_type c;
      c.mx      = mx;
      c.my      = my;
      c.acc_op  = ao;
      c.base_op = bo;
      c.exp_op  = eo;
      c.seq     = sq;
      c.target  = tg;
      return c;
   endfunction

   function automatic ctrl_type ucode_rom(step_type s);
      ctrl_type c;
      case (s)
         UC_ADD:      c = mk_ctrl(MX_OPA, MY_OPB, ACC_XOR, BASE_HOLD, EXP_HOLD,
                                  SEQ_DONE, UC_ADD);
         UC_NEG:      c = mk_ctrl(MX_OPA, MY_OPB, ACC_OPA, BASE_HOLD, EXP_HOLD,
                                  SEQ_DONE, UC_ADD);
         UC_MUL:      c = mk_ctrl(MX_OPA, MY_OPB, ACC_MUL, BASE_HOLD, EXP_HOLD,
                                  SEQ_DONE, UC_ADD);
         UC_ZERO:     c = mk_ctrl(MX_OPA, MY_OPB, ACC_ZERO, BASE_HOLD, EXP_HOLD,
                                  SEQ_DONE, UC_ADD);
         UC_INV:      c = mk_ctrl(MX_ACC, MY_BASE, ACC_ONE, BASE_OPA, EXP_INV,
                                  SEQ_NEXT, UC_ADD);
         UC_INV_MUL:  c = mk_ctrl(MX_ACC, MY_BASE, ACC_MUL_BIT, BASE_HOLD, EXP_HOLD,
                                  SEQ_DONE_IF_ZERO, UC_ADD);
         UC_INV_SQR:  c = mk_ctrl(MX_BASE, MY_BASE, ACC_HOLD, BASE_MUL, EXP_SHIFT,
                                  SEQ_JUMP, UC_INV_MUL);
         UC_DIV:      c = mk_ctrl(MX_ACC, MY_BASE, ACC_ONE, BASE_OPB, EXP_INV,
                                  SEQ_NEXT, UC_ADD);
         UC_DIV_MUL:  c = mk_ctrl(MX_ACC, MY_BASE, ACC_MUL_BIT, BASE_HOLD, EXP_HOLD,
                                  SEQ_JUMP_IF_ZERO, UC_DIV_FIN);
         UC_DIV_SQR:  c = mk_ctrl(MX_BASE, MY_BASE, ACC_HOLD, BASE_MUL, EXP_SHIFT,
                                  SEQ_JUMP, UC_DIV_MUL);
         UC_DIV_FIN:  c = mk_ctrl(MX_ACC, MY_OPA, ACC_MUL, BASE_HOLD, EXP_HOLD,
                                  SEQ_DONE, UC_ADD);
         UC_PPOW:     c = mk_ctrl(MX_ACC, MY_BASE, ACC_ONE, BASE_OPA, EXP_OPB,
                                  SEQ_JUMP, UC_INV_MUL);
         UC_NPOW:     c = mk_ctrl(MX_ACC, MY_BASE, ACC_ONE, BASE_OPA, EXP_INV,
                                  SEQ_NEXT, UC_ADD);
         UC_NPOW_MUL: c = mk_ctrl(MX_ACC, MY_BASE, ACC_MUL_BIT, BASE_HOLD, EXP_HOLD,
                                  SEQ_JUMP_IF_ZERO, UC_NPOW_RUN);
         UC_NPOW_SQR: c = mk_ctrl(MX_BASE, MY_BASE, ACC_HOLD, BASE_MUL, EXP_SHIFT,
                                  SEQ_JUMP, UC_NPOW_MUL);
         UC_NPOW_RUN: c = mk_ctrl(MX_ACC, MY_BASE, ACC_ONE, BASE_ACC, EXP_MAG,
                                  SEQ_JUMP, UC_INV_MUL);
         default:     c = mk_ctrl(MX_OPA, MY_OPB, ACC_ZERO, BASE_HOLD, EXP_HOLD,
                                  SEQ_DONE, UC_ADD);
      endcase
      return c;
   endfunction

endpackage

FILE: sv/bfau_if.sv
// ----------------------------------------------------------------------------
// bfau request and response channels
// Valid/ready channels carrying the operation and its result.
// ----------------------------------------------------------------------------
interface bfau_req_if import bfau_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [KIND_BITS-1:0]    kind;
   logic [OPERAND_BITS-1:0] operand_a;
   logic [OPERAND_BITS-1:0] operand_b;

   modport source (output valid, output kind, output operand_a, output operand_b,
                   input ready);
   modport sink (input valid, input kind, input operand_a, input operand_b,
                 output ready);
endinterface

interface bfau_rsp_if import bfau_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [OPERAND_BITS-1:0] result;
   logic                    error;

   modport source (output valid, output result, output error, input ready);
   modport sink (input valid, input result, input error, output ready);
endinterface

FILE: sv/binary_field_arithmetic_unit_top.sv
// ----------------------------------------------------------------------------
// binary_field_arithmetic_unit_top
// GF(2^m) add, negate, multiply, inverse, divide and power, run by microcode.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  req_if   in         valid/ready               kind, operand_a, operand_b
//  rsp_if   out        valid/ready               result, error
//  csr_*    in         APB write/read, pready=1  reduction_poly at 0x0
//
//  Add, sub, neg, mul and error cases finish at their entry step; inverse,
//  divide and power loop square and multiply over the exponent bits; one
//  step per cycle, bounded by the single shared field multiplier.
//  A request is taken whenever no request is in progress; one result waits in
//  the output register while the next request runs. A stalled output holds
//  the final step. Reset is synchronous and sets reduction_poly to 141.
// ----------------------------------------------------------------------------
module binary_field_arithmetic_unit_top import bfau_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   bfau_req_if.sink                 req_if,
   bfau_rsp_if.source               rsp_if,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   logic                     busy_ff, busy_in;
   step_type                 step_ff, step_in;
   elem_type                 acc_ff, acc_in;
   elem_type                 base_ff, base_in;
   exp_type                  exp_ff, exp_in;
   elem_type                 opa_ff, opa_in;
   logic [OPERAND_BITS-1:0]  opb_ff, opb_in;
   logic                     err_ff, err_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [OPERAND_BITS-1:0]  rsp_result_ff, rsp_result_in;
   logic                     rsp_error_ff, rsp_error_in;
   logic [CSR_DATA_BITS-1:0] poly_ff, poly_in;

   ctrl_type                 ctrl;
   elem_type                 mul_x, mul_y, mul_p, opb_elem;
   logic                     exp_zero, rsp_free, finish, advance, accept, req_err;
   elem_type                 req_a, req_b;
   step_type                 entry;
   logic [CSR_IDX_BITS-1:0]  csr_idx;

   assign ctrl       = ucode_rom(step_ff);
   assign opb_elem   = opb_ff[FIELD_BITS-1:0];
   assign exp_zero   = (exp_ff == '0);
   assign rsp_free   = !rsp_valid_ff || rsp_if.ready;
   assign finish     = busy_ff && ((ctrl.seq == SEQ_DONE) ||
                                   ((ctrl.seq == SEQ_DONE_IF_ZERO) && exp_zero));
   assign advance    = busy_ff && (!finish || rsp_free);
   assign accept     = req_if.valid && req_if.ready;
   assign req_if.ready = !busy_ff;
   assign req_a      = req_if.operand_a[FIELD_BITS-1:0];
   assign req_b      = req_if.operand_b[FIELD_BITS-1:0];
   assign csr_idx    = csr_paddr[CSR_ADDR_BITS-1:2];
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_idx == REG_POLY_IDX) ? poly_ff : '0;

   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.result = rsp_result_ff;
   assign rsp_if.error  = rsp_error_ff;

   always_comb begin
      case (ctrl.mx)
         MX_ACC:  mul_x = acc_ff;
         MX_BASE: mul_x = base_ff;
         MX_OPA:  mul_x = opa_ff;
         default: mul_x = acc_ff;
      endcase
      case (ctrl.my)
         MY_BASE: mul_y = base_ff;
         MY_OPA:  mul_y = opa_ff;
         MY_OPB:  mul_y = opb_elem;
         default: mul_y = base_ff;
      endcase
   end

   assign mul_p = gf_mul(mul_x, mul_y, poly_ff[FIELD_BITS-1:0]);

   always_comb begin
      req_err = 1'b0;
      case (kind_type'(req_if.kind))
         KIND_ADD: entry = UC_ADD;
         KIND_SUB: entry = UC_ADD;
         KIND_NEG: entry = UC_NEG;
         KIND_MUL: entry = UC_MUL;
         KIND_INV: begin
            entry   = UC_INV;
            req_err = (req_a == '0);
         end
         KIND_DIV: begin
            entry   = UC_DIV;
            req_err = (req_b == '0);
         end
         KIND_POW: begin
            entry   = req_if.operand_b[OPERAND_BITS-1] ? UC_NPOW : UC_PPOW;
            req_err = req_if.operand_b[OPERAND_BITS-1] && (req_a == '0);
         end
         default: entry = UC_ZERO;
      endcase
      if (req_err) begin
         entry = UC_ZERO;
      end
   end

   always_comb begin
      busy_in       = busy_ff;
      step_in       = step_ff;
      acc_in        = acc_ff;
      base_in       = base_ff;
      exp_in        = exp_ff;
      opa_in        = opa_ff;
      opb_in        = opb_ff;
      err_in        = err_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_result_in = rsp_result_ff;
      rsp_error_in  = rsp_error_ff;
      poly_in       = poly_ff;

      case (ctrl.acc_op)
         ACC_HOLD:    acc_in = acc_ff;
         ACC_ONE:     acc_in = ELEM_ONE;
         ACC_ZERO:    acc_in = '0;
         ACC_XOR:     acc_in = opa_ff ^ opb_elem;
         ACC_OPA:     acc_in = opa_ff;
         ACC_MUL:     acc_in = mul_p;
         ACC_MUL_BIT: acc_in = exp_ff[0] ? mul_p : acc_ff;
         default:     acc_in = acc_ff;
      endcase
      case (ctrl.base_op)
         BASE_HOLD: base_in = base_ff;
         BASE_OPA:  base_in = opa_ff;
         BASE_OPB:  base_in = opb_elem;
         BASE_ACC:  base_in = acc_ff;
         BASE_MUL:  base_in = mul_p;
         default:   base_in = base_ff;
      endcase
      case (ctrl.exp_op)
         EXP_HOLD:  exp_in = exp_ff;
         EXP_INV:   exp_in = INV_EXP;
         EXP_OPB:   exp_in = EXP_BITS'(opb_ff);
         EXP_MAG:   exp_in = EXP_BITS'(~opb_ff + 1'b1);
         EXP_SHIFT: exp_in = exp_ff >> 1;
         default:   exp_in = exp_ff;
      endcase
      case (ctrl.seq)
         SEQ_NEXT:         step_in = step_ff + 1'b1;
         SEQ_JUMP:         step_in = ctrl.target;
         SEQ_JUMP_IF_ZERO: step_in = exp_zero ? ctrl.target : step_ff + 1'b1;
         SEQ_DONE:         step_in = step_ff;
         SEQ_DONE_IF_ZERO: step_in = exp_zero ? step_ff : step_ff + 1'b1;
         default:          step_in = step_ff;
      endcase

      if (!advance) begin
         acc_in  = acc_ff;
         base_in = base_ff;
         exp_in  = exp_ff;
         step_in = step_ff;
      end

      if (finish && rsp_free) begin
         busy_in       = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_result_in = OPERAND_BITS'(acc_in);
         rsp_error_in  = err_ff;
      end

      if (accept) begin
         busy_in = 1'b1;
         step_in = entry;
         opa_in  = req_a;
         opb_in  = req_if.operand_b;
         err_in  = req_err;
      end

      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          (csr_idx == REG_POLY_IDX)) begin
         poly_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= UC_ZERO;
         rsp_valid_ff <= 1'b0;
         poly_ff      <= POLY_RESET;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         poly_ff      <= poly_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff        <= acc_in;
      base_ff       <= base_in;
      exp_ff        <= exp_in;
      opa_ff        <= opa_in;
      opb_ff        <= opb_in;
      err_ff        <= err_in;
      rsp_result_ff <= rsp_result_in;
      rsp_error_ff  <= rsp_error_in;
   end

endmodule

FILE: test/binary_field_arithmetic_unit_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_field_arithmetic_unit_top_tb
// Drives GF(2^m) requests with random gaps and output stalls and checks every
// result and error flag against an in-bench field predictor. Also runs the
// reduction polynomial through irreducible, reducible and extreme settings.
// ----------------------------------------------------------------------------
module binary_field_arithmetic_unit_top_tb;
   import bfau_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 4 * FIELD_BITS + 80;
   localparam logic [KIND_BITS-1:0]     KIND_UNUSED = 3'd7;
   localparam logic [CSR_ADDR_BITS-1:0] POLY_ADDR   = {REG_POLY_IDX, 2'b00};

   typedef logic [OPERAND_BITS-1:0] word_type;

   typedef struct packed {
      word_type result;
      logic     error;
   } field_outcome_type;

   logic clock;
   logic reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   bfau_req_if req_bus ();
   bfau_rsp_if rsp_bus ();

   field_outcome_type          pending_outcomes[$];
   logic [CSR_DATA_BITS-1:0]   active_poly;
   int                         error_count;
   int                         cycle_count;
   int                         stall_left;
   bit                         gaps_on;
   bit                         backpressure_on;

   binary_field_arithmetic_unit_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic elem_type field_product(elem_type x, elem_type y, elem_type poly);
      elem_type sum;
      logic     carry;
      sum = '0;
      for (int i = 0; i < FIELD_BITS; i++) begin
         if (y[i]) begin
            sum = sum ^ x;
         end
         carry = x[FIELD_BITS-1];
         x = x << 1;
         if (carry) begin
            x = x ^ poly;
         end
      end
      return sum;
   endfunction

   function automatic elem_type field_power(elem_type base, exp_type e, elem_type poly);
      elem_type acc;
      acc = elem_type'(1);
      for (int i = 0; i < EXP_BITS; i++) begin
         if (e[i]) begin
            acc = field_product(acc, base, poly);
         end
         base = field_product(base, base, poly);
      end
      return acc;
   endfunction

   function automatic elem_type field_inverse(elem_type x, elem_type poly);
      exp_type order_less_two;
      order_less_two = exp_type'({FIELD_BITS{1'b1}}) - exp_type'(1);
      return field_power(x, order_less_two, poly);
   endfunction

   function automatic field_outcome_type predict_outcome(logic [KIND_BITS-1:0] kind,
                                                         word_type a_raw, word_type b_raw);
      field_outcome_type outcome;
      elem_type          a;
      elem_type          b;
      elem_type          poly;
      elem_type          value;
      exp_type           magnitude;
      a         = a_raw[FIELD_BITS-1:0];
      b         = b_raw[FIELD_BITS-1:0];
      poly      = active_poly[FIELD_BITS-1:0];
      value     = '0;
      outcome   = '0;
      case (kind)
         KIND_ADD, KIND_SUB: value = a ^ b;
         KIND_NEG:           value = a;
         KIND_MUL:           value = field_product(a, b, poly);
         KIND_INV: begin
            if (a == '0) outcome.error = 1'b1;
            else value = field_inverse(a, poly);
         end
         KIND_DIV: begin
            if (b == '0) outcome.error = 1'b1;
            else if (a != '0) value = field_product(a, field_inverse(b, poly), poly);
         end
         KIND_POW: begin
            if (b_raw[EXP_BITS-1]) begin
               magnitude = ~exp_type'(b_raw) + exp_type'(1);
               if (a == '0) outcome.error = 1'b1;
               else value = field_power(field_inverse(a, poly), magnitude, poly);
            end else begin
               value = field_power(a, exp_type'(b_raw), poly);
            end
         end
         default: value = '0;
      endcase
      outcome.result = word_type'(value);
      return outcome;
   endfunction

   function automatic word_type pick_operand();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return word_type'(1);
         2:       return '1;
         3:       return word_type'(1) << $urandom_range(0, OPERAND_BITS - 1);
         default: return word_type'($urandom);
      endcase
   endfunction

   function automatic word_type pick_exponent();
      case ($urandom_range(0, 7))
         0:       return word_type'($urandom_range(0, 16));
         1:       return -word_type'($urandom_range(1, 16));
         2:       return 32'h8000_0000;
         3:       return 32'h7fff_ffff;
         default: return word_type'($urandom);
      endcase
   endfunction

   always @(negedge clock) begin
      if (backpressure_on && stall_left == 0 && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 6);
      end
      if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      field_outcome_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h error %b",
                     $time, rsp_bus.result, rsp_bus.error);
            error_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_bus.result !== want.result) begin
               $display("%0t: result mismatch, expected %h, actual %h",
                        $time, want.result, rsp_bus.result);
               error_count++;
            end
            if (rsp_bus.error !== want.error) begin
               $display("%0t: error flag mismatch, expected %b, actual %b",
                        $time, want.error, rsp_bus.error);
               error_count++;
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   task automatic send_request(input logic [KIND_BITS-1:0] kind, input word_type a,
                               input word_type b);
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.kind      <= kind;
      req_bus.operand_a <= a;
      req_bus.operand_b <= b;
      do @(posedge clock); while (!req_bus.ready);
      pending_outcomes.push_back(predict_outcome(kind, a, b));
   endtask

   task automatic drain_requests();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic read_polynomial(input logic [CSR_DATA_BITS-1:0] want);
      @(negedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b0;
      csr_paddr  <= POLY_ADDR;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) begin
         $display("%0t: polynomial readback mismatch, expected %h, actual %h",
                  $time, want, csr_prdata);
         error_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic program_polynomial(input logic [CSR_DATA_BITS-1:0] value);
      drain_requests();
      @(negedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= POLY_ADDR;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      active_poly = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      read_polynomial(value);
   endtask

   task automatic test_polynomial_reset_value();
      read_polynomial(POLY_RESET);
   endtask

   task automatic test_directed_cases();
      send_request(KIND_ADD, 32'h0000_0000, 32'h0000_0000);
      send_request(KIND_ADD, 32'hffff_ffff, 32'hffff_ffff);
      send_request(KIND_SUB, 32'h1234_5678, 32'hffff_ffff);
      send_request(KIND_NEG, 32'hffff_ffff, 32'h0000_0000);
      send_request(KIND_NEG, 32'h0000_0000, 32'hffff_ffff);
      send_request(KIND_MUL, 32'hffff_ffff, 32'hffff_ffff);
      send_request(KIND_MUL, 32'h8000_0000, 32'h0000_0002);
      send_request(KIND_MUL, 32'h0000_0000, 32'hffff_ffff);
      send_request(KIND_INV, 32'h0000_0000, 32'h5a5a_5a5a);
      send_request(KIND_INV, 32'h0000_0001, 32'h0000_0000);
      send_request(KIND_INV, 32'hffff_ffff, 32'hffff_ffff);
      send_request(KIND_DIV, 32'hdead_beef, 32'h0000_0000);
      send_request(KIND_DIV, 32'h0000_0000, 32'h0000_0007);
      send_request(KIND_DIV, 32'hffff_ffff, 32'h8000_0000);
      send_request(KIND_POW, 32'h0000_0000, 32'h0000_0000);
      send_request(KIND_POW, 32'h0000_0000, 32'hffff_ffff);
      send_request(KIND_POW, 32'h0000_0000, 32'h0000_0005);
      send_request(KIND_POW, 32'h0000_0003, 32'h8000_0000);
      send_request(KIND_POW, 32'h0000_0002, 32'h7fff_ffff);
      send_request(KIND_POW, 32'h0000_0005, 32'hffff_ffff);
      send_request(KIND_POW, 32'hffff_ffff, 32'h0000_0002);
      send_request(KIND_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
   endtask

   task automatic test_random_operations(input int count);
      logic [KIND_BITS-1:0] kind;
      word_type             a;
      word_type             b;
      int                   pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 20);
         kind = (pick == 20) ? KIND_UNUSED : KIND_BITS'(pick % 7);
         a    = pick_operand();
         b    = (kind == KIND_POW) ? pick_exponent() : pick_operand();
         send_request(kind, a, b);
      end
   endtask

   task automatic test_polynomial_sweep();
      logic [CSR_DATA_BITS-1:0] polys[4];
      polys[0] = 32'h0040_0007;
      polys[1] = 32'h0000_0000;
      polys[2] = 32'hffff_ffff;
      polys[3] = CSR_DATA_BITS'($urandom);
      foreach (polys[i]) begin
         program_polynomial(polys[i]);
         test_random_operations(90);
      end
   endtask

   task automatic test_unthrottled_stream();
      program_polynomial(POLY_RESET);
      gaps_on         = 1'b0;
      backpressure_on = 1'b0;
      test_random_operations(170);
   endtask

   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.kind      = '0;
      req_bus.operand_a = '0;
      req_bus.operand_b = '0;
      rsp_bus.ready     = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      active_poly       = POLY_RESET;
      error_count       = 0;
      stall_left        = 0;
      gaps_on           = 1'b1;
      backpressure_on   = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_polynomial_reset_value();
      test_directed_cases();
      test_random_operations(300);
      test_polynomial_sweep();
      test_unthrottled_stream();

      drain_requests();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/bfau_pkg.sv
sv/bfau_if.sv
sv/binary_field_arithmetic_unit_top.sv
test/binary_field_arithmetic_unit_top_tb.sv
